@@ design/strict_priority_four_class_queue_macros.svh @@
`ifndef STRICT_PRIORITY_FOUR_CLASS_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_FOUR_CLASS_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, ignored while reset is asserted.
`define SPFQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spfq assertion failed");

// Condition that must never be true outside reset.
`define SPFQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("spfq forbidden condition seen");

`else

`define SPFQ_ASSERT(label, clk, rst_n, prop)
`define SPFQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ design/spfq_pkg.sv @@
`default_nettype none

package spfq_pkg;

    localparam int NUM_CLASSES  = 4;
    localparam int CLASS_W      = 2;
    localparam int TICKET_W     = 16;
    localparam int HOUR_W       = 5;
    localparam int MINUTE_W     = 6;
    localparam int WAIT_W       = 11;
    localparam int PEAK_W       = 9;
    localparam int COUNT_W      = 16;
    localparam int WAITING_W    = 7;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam int                  MIN_PER_HOUR = 60;
    localparam logic [WAIT_W-1:0]   WAIT_MAX   = 11'd2047;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 16'hFFFF;
    localparam int                  PEAK_MAX   = 511;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_SERVE = 1'b1;

    localparam logic [2:0] ST_ADMITTED    = 3'd0;
    localparam logic [2:0] ST_BAD_CLASS   = 3'd1;
    localparam logic [2:0] ST_BAD_TIME    = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL  = 3'd3;
    localparam logic [2:0] ST_SERVED      = 3'd4;
    localparam logic [2:0] ST_SERVED_BAD  = 3'd5;
    localparam logic [2:0] ST_NONE_WAITING = 3'd6;

    typedef struct packed {
        logic                kind;
        logic [TICKET_W-1:0] ticket_id;
        logic [2:0]          class_code;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [TICKET_W-1:0]  served_ticket;
        logic [CLASS_W-1:0]   served_class;
        logic [WAIT_W-1:0]    wait_minutes;
        logic [WAIT_W-1:0]    longest_wait;
        logic [PEAK_W-1:0]    peak_waiting;
        logic [COUNT_W-1:0]   total_served;
        logic [COUNT_W-1:0]   served_in_class;
        logic [WAITING_W-1:0] waiting_class0;
        logic [WAITING_W-1:0] waiting_class1;
        logic [WAITING_W-1:0] waiting_class2;
        logic [WAITING_W-1:0] waiting_class3;
    } out_item_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                kind;
        logic                class_bad;
        logic                time_ok;
        logic [CLASS_W-1:0]  cls;
        logic [TICKET_W-1:0] ticket_id;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

`default_nettype wire

@@ design/strict_priority_four_class_queue.sv @@
// Strict-priority four-class ticket queue.
// Input channel: drive request and raise push; the item transfers on a clock
// edge with push high and full low. kind selects admit (enqueue a ticket of
// class 0..3 stamped hour:minute) or serve (pop the oldest ticket of the
// highest non-empty class, class 0 first).
// Result channel: one result per item, in order. While empty is low the
// oldest result sits on result; it transfers on an edge with pop high.
// An item moves from the command queue to the back end, which reads the
// ticket memory into a register (IDLE) and then updates and pushes the result
// (EXEC); it takes no new item until it is through with the last one.
// A 2-entry command queue in front and a 2-entry result queue behind let
// input and output stall independently; when the receiver stops popping the
// back end halts once the result queue fills, and full rises after the
// command queue fills.
// Reset: all queues empty, pointers, counts, peaks and longest wait zeroed.
// The ticket memory is not cleared; only written slots are ever read.
// Ticket memory holds 4 x QUEUE_DEPTH (rounded up to a power of two) entries.
`default_nettype none

module strict_priority_four_class_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TICKET_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire spfq_pkg::in_item_t  request,
    output logic                     empty,
    input  wire logic                pop,
    output spfq_pkg::out_item_t      result
);

    // front -> back command handoff
    logic                cmd_valid;
    logic                cmd_take;
    spfq_pkg::cmd_t      cmd;

    // back -> result queue
    logic                res_room;
    logic                res_push;
    spfq_pkg::out_item_t res;

    // front end: range checks on class and time, small command queue
    spfq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back end: per-class ring buffers, counters, wait math
    spfq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICKET_BITS (TICKET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_room  (res_room),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue decouples the receiver from the back end
    spfq_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .res    (res),
        .room   (res_room),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

@@ design/spfq_front.sv @@
`default_nettype none

module spfq_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire spfq_pkg::in_item_t request,
    output logic                   cmd_valid,
    output spfq_pkg::cmd_t         cmd,
    input  wire logic              cmd_take
);

    localparam int DEPTH = 2;

    spfq_pkg::cmd_t slot_reg [DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    spfq_pkg::cmd_t classified;
    logic           accept;

    // range checks done on the way in
    always_comb
    begin
        classified.kind      = request.kind;
        classified.class_bad = request.class_code[2];
        classified.time_ok   = (request.hour <= spfq_pkg::HOUR_MAX) &&
                               (request.minute <= spfq_pkg::MINUTE_MAX);
        classified.cls       = request.class_code[spfq_pkg::CLASS_W-1:0];
        classified.ticket_id = request.ticket_id;
        classified.hour      = request.hour;
        classified.minute    = request.minute;
    end

    assign full      = (count_reg == 2'(DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(accept) - 2'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

@@ design/spfq_outq.sv @@
`default_nettype none

`include "strict_priority_four_class_queue_macros.svh"

module spfq_outq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire spfq_pkg::out_item_t res,
    output logic                     room,
    output logic                     empty,
    input  wire logic                pop,
    output spfq_pkg::out_item_t      result
);

    localparam int DEPTH = 2;

    spfq_pkg::out_item_t slot_reg [DEPTH];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                take;

    assign room   = (count_reg != 2'(DEPTH));
    assign empty  = (count_reg == 2'd0);
    assign take   = pop && !empty;
    assign result = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

    // back end only pushes after checking room
    `SPFQ_ASSERT_NEVER(a_outq_overflow, clk, rst_n, push && (count_reg == 2'(DEPTH)))

endmodule

`default_nettype wire

@@ design/spfq_back.sv @@
`default_nettype none

`include "strict_priority_four_class_queue_macros.svh"

module spfq_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TICKET_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire spfq_pkg::cmd_t cmd,
    output logic                cmd_take,
    input  wire logic           res_room,
    output logic                res_push,
    output spfq_pkg::out_item_t res
);

    localparam int NC        = spfq_pkg::NUM_CLASSES;
    localparam int IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W     = $clog2(NC * QUEUE_DEPTH + 1);
    localparam int CMP_W     = (TOT_W > spfq_pkg::PEAK_W) ? TOT_W : spfq_pkg::PEAK_W;
    localparam int STORE_TB  = (TICKET_BITS < spfq_pkg::TICKET_W) ? TICKET_BITS
                                                                  : spfq_pkg::TICKET_W;
    localparam int ENTRY_W   = STORE_TB + spfq_pkg::HOUR_W + spfq_pkg::MINUTE_W;
    localparam int ADDR_W    = spfq_pkg::CLASS_W + IDX_W;
    localparam int MEM_DEPTH = NC << IDX_W;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
    localparam logic [CMP_W-1:0]  PEAK_CAP  = CMP_W'(spfq_pkg::PEAK_MAX);

    // ticket entries, class c in rows {c, index}
    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    spfq_pkg::back_state_t state_reg, state_next;
    spfq_pkg::cmd_t        cmd_reg;
    logic [spfq_pkg::CLASS_W-1:0] sel_reg, sel_pick;
    logic                  any_reg, any_pick;

    logic [IDX_W-1:0]   head_reg [NC];
    logic [IDX_W-1:0]   head_next [NC];
    logic [IDX_W-1:0]   tail_reg [NC];
    logic [IDX_W-1:0]   tail_next [NC];
    logic [FILL_W-1:0]  fill_reg [NC];
    logic [FILL_W-1:0]  fill_next [NC];
    logic [spfq_pkg::COUNT_W-1:0] cls_cnt_reg [NC];
    logic [spfq_pkg::COUNT_W-1:0] cls_cnt_next [NC];
    logic [spfq_pkg::COUNT_W-1:0] served_reg, served_next;
    logic [spfq_pkg::WAIT_W-1:0]  max_wait_reg, max_wait_next;
    logic [spfq_pkg::PEAK_W-1:0]  peak_reg, peak_next;
    logic [TOT_W-1:0]   total_reg, total_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;

    logic [STORE_TB-1:0]              ent_ticket;
    logic [spfq_pkg::HOUR_W-1:0]      ent_hour;
    logic [spfq_pkg::MINUTE_W-1:0]    ent_minute;
    logic signed [12:0]               d_hour, d_min, wait_raw;
    logic [spfq_pkg::WAIT_W-1:0]      wait_val;
    logic [CMP_W-1:0]                 tot_ext;
    logic [spfq_pkg::COUNT_W-1:0]     cnt_new;

    // highest-priority non-empty class, lowest index first
    always_comb
    begin
        sel_pick = '0;
        any_pick = 1'b0;
        for (int c = NC - 1; c >= 0; c--)
        begin
            if (fill_reg[c] != '0)
            begin
                sel_pick = spfq_pkg::CLASS_W'(c);
                any_pick = 1'b1;
            end
        end
    end

    assign rd_addr = {sel_pick, head_reg[sel_pick]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spfq_pkg::BK_IDLE: if (cmd_valid && res_room) state_next = spfq_pkg::BK_EXEC;
            spfq_pkg::BK_EXEC: state_next = spfq_pkg::BK_IDLE;
            default:           state_next = spfq_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_take = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            spfq_pkg::BK_IDLE: cmd_take = cmd_valid && res_room;
            spfq_pkg::BK_EXEC: res_push = 1'b1;
            default:           cmd_take = 1'b0;
        endcase
    end

    assign ent_ticket = rd_data_reg[ENTRY_W-1 -: STORE_TB];
    assign ent_hour   = rd_data_reg[spfq_pkg::HOUR_W + spfq_pkg::MINUTE_W - 1
                                    -: spfq_pkg::HOUR_W];
    assign ent_minute = rd_data_reg[spfq_pkg::MINUTE_W-1:0];

    // wait = dh*60 + dm, 60 = 64 - 4
    always_comb
    begin
        d_hour   = $signed({8'd0, cmd_reg.hour}) - $signed({8'd0, ent_hour});
        d_min    = $signed({7'd0, cmd_reg.minute}) - $signed({7'd0, ent_minute});
        wait_raw = (d_hour <<< 6) - (d_hour <<< 2) + d_min;
        if (wait_raw < 0)
            wait_val = '0;
        else if (wait_raw > $signed(13'(spfq_pkg::WAIT_MAX)))
            wait_val = spfq_pkg::WAIT_MAX;
        else
            wait_val = wait_raw[spfq_pkg::WAIT_W-1:0];
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        cls_cnt_next  = cls_cnt_reg;
        served_next   = served_reg;
        max_wait_next = max_wait_reg;
        peak_next     = peak_reg;
        total_next    = total_reg;
        mem_we        = 1'b0;
        wr_addr       = {cmd_reg.cls, tail_reg[cmd_reg.cls]};
        wr_data       = {cmd_reg.ticket_id[STORE_TB-1:0], cmd_reg.hour, cmd_reg.minute};
        tot_ext       = CMP_W'(total_reg + TOT_W'(1));
        cnt_new       = cls_cnt_reg[sel_reg];
        res           = '0;
        res.status    = spfq_pkg::ST_NONE_WAITING;

        if (state_reg == spfq_pkg::BK_EXEC)
        begin
            if (cmd_reg.kind == spfq_pkg::KIND_ADMIT)
            begin
                if (cmd_reg.class_bad)
                    res.status = spfq_pkg::ST_BAD_CLASS;
                else if (!cmd_reg.time_ok)
                    res.status = spfq_pkg::ST_BAD_TIME;
                else if (fill_reg[cmd_reg.cls] == FULL_FILL)
                    res.status = spfq_pkg::ST_QUEUE_FULL;
                else
                begin
                    res.status = spfq_pkg::ST_ADMITTED;
                    mem_we     = 1'b1;
                    tail_next[cmd_reg.cls] = (tail_reg[cmd_reg.cls] == LAST_IDX)
                                           ? '0 : tail_reg[cmd_reg.cls] + IDX_W'(1);
                    fill_next[cmd_reg.cls] = fill_reg[cmd_reg.cls] + FILL_W'(1);
                    total_next = total_reg + TOT_W'(1);
                    if (tot_ext > PEAK_CAP)
                        tot_ext = PEAK_CAP;
                    if (tot_ext > CMP_W'(peak_reg))
                        peak_next = tot_ext[spfq_pkg::PEAK_W-1:0];
                end
            end
            else if (any_reg)
            begin
                res.status = cmd_reg.time_ok ? spfq_pkg::ST_SERVED : spfq_pkg::ST_SERVED_BAD;
                head_next[sel_reg] = (head_reg[sel_reg] == LAST_IDX)
                                   ? '0 : head_reg[sel_reg] + IDX_W'(1);
                fill_next[sel_reg] = fill_reg[sel_reg] - FILL_W'(1);
                total_next = total_reg - TOT_W'(1);
                if (cnt_new != spfq_pkg::COUNT_MAX)
                    cnt_new = cnt_new + 16'd1;
                cls_cnt_next[sel_reg] = cnt_new;
                if (served_reg != spfq_pkg::COUNT_MAX)
                    served_next = served_reg + 16'd1;
                if (wait_val > max_wait_reg)
                    max_wait_next = wait_val;
                res.served_ticket   = spfq_pkg::TICKET_W'(ent_ticket);
                res.served_class    = sel_reg;
                res.wait_minutes    = wait_val;
                res.served_in_class = cnt_new;
            end
        end

        res.longest_wait   = max_wait_next;
        res.peak_waiting   = peak_next;
        res.total_served   = served_next;
        res.waiting_class0 = spfq_pkg::WAITING_W'(fill_next[0]);
        res.waiting_class1 = spfq_pkg::WAITING_W'(fill_next[1]);
        res.waiting_class2 = spfq_pkg::WAITING_W'(fill_next[2]);
        res.waiting_class3 = spfq_pkg::WAITING_W'(fill_next[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spfq_pkg::BK_IDLE;
            served_reg   <= '0;
            max_wait_reg <= '0;
            peak_reg     <= '0;
            total_reg    <= '0;
            for (int c = 0; c < NC; c++)
            begin
                head_reg[c]    <= '0;
                tail_reg[c]    <= '0;
                fill_reg[c]    <= '0;
                cls_cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            served_reg   <= served_next;
            max_wait_reg <= max_wait_next;
            peak_reg     <= peak_next;
            total_reg    <= total_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            cls_cnt_reg  <= cls_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd;
            sel_reg <= sel_pick;
            any_reg <= any_pick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (cmd_take)
            rd_data_reg <= mem[rd_addr];
    end

    `SPFQ_ASSERT(a_take_then_result, clk, rst_n, cmd_take |=> res_push)
    `SPFQ_ASSERT(a_total_matches, clk, rst_n,
                 total_reg == TOT_W'(fill_reg[0]) + TOT_W'(fill_reg[1])
                              + TOT_W'(fill_reg[2]) + TOT_W'(fill_reg[3]))
    `SPFQ_ASSERT_NEVER(a_write_into_full, clk, rst_n, mem_we && (fill_reg[cmd_reg.cls] == FULL_FILL))

endmodule

`default_nettype wire

@@ test/ticket_queue_checker.sv @@
module ticket_queue_checker #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TICKET_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  spfq_pkg::in_item_t  request,
    input  logic                empty,
    input  logic                pop,
    input  spfq_pkg::out_item_t result,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spfq_pkg::*;

    localparam logic [TICKET_W-1:0] TICKET_KEEP = TICKET_W'((64'd1 << TICKET_BITS) - 64'd1);

    typedef struct {
        logic [TICKET_W-1:0] ticket;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } stamp_t;

    // per-class ticket lines, oldest at the front
    stamp_t             lane[NUM_CLASSES][$];
    logic [COUNT_W-1:0] class_served[NUM_CLASSES];
    logic [COUNT_W-1:0] served_total;
    logic [WAIT_W-1:0]  longest;
    int                 peak;
    out_item_t          awaited_results[$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        served_total = '0;
        longest      = '0;
        peak         = 0;
        foreach (class_served[c])
            class_served[c] = '0;
    end

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Applies one item to the shadow queues and returns the result it yields.
    function automatic out_item_t predict_outcome(in_item_t it);
        out_item_t r;
        stamp_t    s;
        int        pick;
        int        w;
        int        total;
        logic      valid_time;
        r          = '0;
        pick       = -1;
        valid_time = (it.hour <= HOUR_MAX) && (it.minute <= MINUTE_MAX);
        if (it.kind == KIND_ADMIT)
        begin
            // class, then time, then room
            if (it.class_code >= NUM_CLASSES)
                r.status = ST_BAD_CLASS;
            else if (!valid_time)
                r.status = ST_BAD_TIME;
            else if (lane[it.class_code].size() >= QUEUE_DEPTH)
                r.status = ST_QUEUE_FULL;
            else
            begin
                s.ticket = it.ticket_id & TICKET_KEEP;
                s.hour   = it.hour;
                s.minute = it.minute;
                lane[it.class_code].push_back(s);
                total = lane[0].size() + lane[1].size() + lane[2].size() + lane[3].size();
                if (total > PEAK_MAX)
                    total = PEAK_MAX;
                if (total > peak)
                    peak = total;
                r.status = ST_ADMITTED;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
                if (pick < 0 && lane[c].size() != 0)
                    pick = c;
            if (pick < 0)
                r.status = ST_NONE_WAITING;
            else
            begin
                s = lane[pick].pop_front();
                // raw service time is used even when it is out of range
                w = (int'(it.hour) - int'(s.hour)) * MIN_PER_HOUR
                  + (int'(it.minute) - int'(s.minute));
                if (w < 0)
                    w = 0;
                if (w > int'(WAIT_MAX))
                    w = int'(WAIT_MAX);
                if (class_served[pick] != COUNT_MAX)
                    class_served[pick]++;
                if (served_total != COUNT_MAX)
                    served_total++;
                if (w > int'(longest))
                    longest = w[WAIT_W-1:0];
                r.served_ticket   = s.ticket;
                r.served_class    = pick[CLASS_W-1:0];
                r.wait_minutes    = w[WAIT_W-1:0];
                r.served_in_class = class_served[pick];
                r.status          = valid_time ? ST_SERVED : ST_SERVED_BAD;
            end
        end
        r.longest_wait   = longest;
        r.peak_waiting   = peak[PEAK_W-1:0];
        r.total_served   = served_total;
        r.waiting_class0 = WAITING_W'(lane[0].size());
        r.waiting_class1 = WAITING_W'(lane[1].size());
        r.waiting_class2 = WAITING_W'(lane[2].size());
        r.waiting_class3 = WAITING_W'(lane[3].size());
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                    report("result transfer with nothing pending");
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", result.status, want.status);
                    check_field("served_ticket", result.served_ticket, want.served_ticket);
                    check_field("served_class", result.served_class, want.served_class);
                    check_field("wait_minutes", result.wait_minutes, want.wait_minutes);
                    check_field("longest_wait", result.longest_wait, want.longest_wait);
                    check_field("peak_waiting", result.peak_waiting, want.peak_waiting);
                    check_field("total_served", result.total_served, want.total_served);
                    check_field("served_in_class", result.served_in_class,
                                want.served_in_class);
                    check_field("waiting_class0", result.waiting_class0, want.waiting_class0);
                    check_field("waiting_class1", result.waiting_class1, want.waiting_class1);
                    check_field("waiting_class2", result.waiting_class2, want.waiting_class2);
                    check_field("waiting_class3", result.waiting_class3, want.waiting_class3);
                end
            end
            if (push && !full)
                awaited_results.push_back(predict_outcome(request));
            pending <= awaited_results.size();
        end
    end

endmodule

@@ test/tb_strict_priority_four_class_queue.sv @@
module tb_strict_priority_four_class_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spfq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int TBITS        = 16;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 100;   // 12 x 100 random items
    localparam int SPREAD       = 4;     // focus value meaning "any valid class"

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  request;
    logic      empty;
    logic      pop;
    out_item_t result;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    bit        steady_sender;  // no gaps on the input side for this phase

    strict_priority_four_class_queue #(
        .QUEUE_DEPTH(DEPTH),
        .TICKET_BITS(TBITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .request(request),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    ticket_queue_checker #(
        .QUEUE_DEPTH(DEPTH),
        .TICKET_BITS(TBITS)
    ) ticket_watch (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Presents one item and returns at the edge where its transfer happens.
    // push stays high between back-to-back items so it never gets two
    // assignments in the same step.
    task automatic drive_item(in_item_t it);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= it;
        push    <= 1'b1;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic admit(logic [15:0] tid, logic [2:0] cls, logic [4:0] h, logic [5:0] m);
        in_item_t it;
        it.kind       = KIND_ADMIT;
        it.ticket_id  = tid;
        it.class_code = cls;
        it.hour       = h;
        it.minute     = m;
        drive_item(it);
    endtask

    task automatic serve(logic [4:0] h, logic [5:0] m);
        in_item_t it;
        it.kind       = KIND_SERVE;
        it.ticket_id  = 16'($urandom);   // ignored by a serve
        it.class_code = 3'($urandom);
        it.hour       = h;
        it.minute     = m;
        drive_item(it);
    endtask

    // One random item: mostly well-formed admits and serves in the ratio the
    // phase asks for, a few with random junk in every field.
    task automatic random_item(int admit_pct, int focus);
        in_item_t it;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            it.kind       = 1'($urandom);
            it.ticket_id  = 16'($urandom);
            it.class_code = 3'($urandom);
            it.hour       = 5'($urandom);
            it.minute     = 6'($urandom);
            drive_item(it);
        end
        else if ($urandom_range(0, 99) < admit_pct)
            admit(16'($urandom),
                  (focus < SPREAD) ? 3'(focus) : 3'($urandom_range(0, 3)),
                  5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
        else if ($urandom_range(0, 99) < 8)
            serve(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
        else
            serve(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
    endtask

    // Result side: pop with random stalls, free-running to the end so a
    // stray late result still transfers and gets flagged.
    initial
    begin : result_drain
        int stall;
        pop   = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Watchdog: a hang on either side stops the transfers.
    initial
        idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles++;
        end
    end

    initial
    begin : stimulus
        int admit_pct;
        int focus;
        push          = 1'b0;
        request       = '0;
        rst_n         = 1'b0;
        steady_sender = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty serve, rejects in check order, field extremes
        serve(5'd10, 6'd0);                      // nothing waiting
        admit(16'h1234, 3'd4, 5'd8, 6'd0);       // bad class
        admit(16'hFFFF, 3'd7, 5'd31, 6'd63);     // bad class wins over bad time
        admit(16'h0001, 3'd2, 5'd24, 6'd0);      // hour out of range
        admit(16'h0002, 3'd1, 5'd0, 6'd60);      // minute out of range
        admit(16'h0003, 3'd0, 5'd31, 6'd63);     // both out of range
        admit(16'h0000, 3'd3, 5'd0, 6'd0);
        admit(16'hFFFF, 3'd3, 5'd23, 6'd59);
        admit(16'hA5A5, 3'd2, 5'd12, 6'd30);
        admit(16'h5A5A, 3'd1, 5'd12, 6'd45);
        admit(16'h00FF, 3'd0, 5'd13, 6'd0);
        admit(16'hFF00, 3'd0, 5'd0, 6'd0);
        serve(5'd13, 6'd5);                      // class 0 first, short wait
        serve(5'd31, 6'd63);                     // bad time still served, longest wait
        serve(5'd12, 6'd0);                      // earlier than arrival: wait clamps
        serve(5'd23, 6'd59);
        serve(5'd0, 6'd0);
        serve(5'd24, 6'd0);                      // bad hour on the last entry
        serve(5'd5, 6'd5);                       // drained again
        admit(16'h0007, 3'd0, 5'd0, 6'd0);
        serve(5'd0, 6'd60);                      // bad minute on a serve

        // random phases: first fill one class past full, then drain, then mix
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                admit_pct = 97;
                focus     = $urandom_range(0, 3);
            end
            else if (p == 1)
            begin
                admit_pct = 15;
                focus     = SPREAD;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: admit_pct = 15;
                    1: admit_pct = 50;
                    2: admit_pct = 75;
                    default: admit_pct = 97;
                endcase
                focus = $urandom_range(0, SPREAD);
            end
            steady_sender = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item(admit_pct, focus);
        end

        // drain: let the last transfer show in pending, then wait out the remaining
        // results and keep watching for anything stray
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/spfq_pkg.sv
design/spfq_front.sv
design/spfq_outq.sv
design/spfq_back.sv
design/strict_priority_four_class_queue.sv
test/ticket_queue_checker.sv
test/tb_strict_priority_four_class_queue.sv
